[hdl/mhpq_pkg.sv]
// Package for the min-heap priority queue: sizes, request and status codes,
// and the control word broadcast to the cell chain. No dependencies.
package mhpq_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type                    op;
      logic signed [VALUE_WIDTH-1:0]  value;
   } cell_ctl_type;

endpackage

[hdl/mhpq_cell.sv]
// One slot of the sorted cell chain: holds a value, compares it with the
// broadcast insert value and shifts toward either neighbor. Uses mhpq_pkg.
module mhpq_cell (
   input  logic                                  clock,
   input  mhpq_pkg::cell_ctl_type                ctl,
   input  logic                                  occupied,
   input  logic                                  left_gt,
   input  logic signed [mhpq_pkg::VALUE_WIDTH-1:0] left_value,
   input  logic signed [mhpq_pkg::VALUE_WIDTH-1:0] right_value,
   output logic                                  gt,
   output logic signed [mhpq_pkg::VALUE_WIDTH-1:0] value
);
   import mhpq_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;

   // empty slots act as +infinity
   assign gt    = !occupied || (value_ff > ctl.value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (gt) begin
               value_in = left_gt ? left_value : ctl.value;
            end
         end
         CELL_SHIFT: begin
            value_in = right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[hdl/min_heap_priority_queue.sv]
// Top level of the min-priority queue: request decode, occupancy count,
// result register and the chain of mhpq_cell slots. Uses mhpq_pkg.
//
// Takes one request every clock cycle; busy stays low. Each request gives
// exactly one result, shown with rsp_valid for one cycle, the cycle after
// the request is accepted. Values are kept sorted in a chain of DEPTH
// cells, smallest at the head; an insert or a pop is one compare-and-shift
// step across all cells, which sets the rate of one request per cycle.
// The receiver cannot stall results.
module min_heap_priority_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_mode,
   input  logic signed [mhpq_pkg::VALUE_WIDTH-1:0] req_insert_value,
   output logic                                    rsp_valid,
   output logic signed [mhpq_pkg::VALUE_WIDTH-1:0] rsp_popped_value,
   output logic [1:0]                              rsp_status,
   output logic [mhpq_pkg::COUNT_WIDTH-1:0]        rsp_occupancy
);
   import mhpq_pkg::*;

   logic                          accept;
   logic                          full;
   logic                          empty;
   cell_ctl_type                  ctl;
   logic [DEPTH-1:0]              gt_vec;
   logic signed [VALUE_WIDTH-1:0] val_arr [DEPTH];

   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type                    rsp_status_ff, rsp_status_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      ctl.op        = CELL_HOLD;
      ctl.value     = req_insert_value;
      count_in      = count_ff;
      rsp_valid_in  = accept;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      if (accept) begin
         if (req_mode == MODE_INSERT) begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               ctl.op   = CELL_INSERT;
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end else begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               ctl.op       = CELL_SHIFT;
               count_in     = count_ff - COUNT_WIDTH'(1);
               rsp_value_in = val_arr[0];
            end
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                          occupied;
      logic                          left_gt;
      logic signed [VALUE_WIDTH-1:0] left_value;
      logic signed [VALUE_WIDTH-1:0] right_value;

      assign occupied = (count_ff > COUNT_WIDTH'(i));

      if (i == 0) begin : g_head
         assign left_gt    = 1'b0;
         assign left_value = req_insert_value;
      end else begin : g_body
         assign left_gt    = gt_vec[i-1];
         assign left_value = val_arr[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = val_arr[i];
      end else begin : g_inner
         assign right_value = val_arr[i+1];
      end

      mhpq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied),
         .left_gt     (left_gt),
         .left_value  (left_value),
         .right_value (right_value),
         .gt          (gt_vec[i]),
         .value       (val_arr[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = count_ff;

endmodule

[hdl/mhpq_checker.sv]
// Port-level checks for min_heap_priority_queue, attached by bind below.
// Uses mhpq_pkg for sizes and status codes.
module mhpq_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    start,
   input logic                                    busy,
   input logic                                    rsp_valid,
   input logic signed [mhpq_pkg::VALUE_WIDTH-1:0] rsp_popped_value,
   input logic [1:0]                              rsp_status,
   input logic [mhpq_pkg::COUNT_WIDTH-1:0]        rsp_occupancy
);
   import mhpq_pkg::*;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (!reset && start && !busy) |=> rsp_valid)
      else $error("accepted request gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without a request");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL)
         |-> (rsp_occupancy == COUNT_WIDTH'(DEPTH) && rsp_popped_value == '0))
      else $error("full status with wrong occupancy or value");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY)
         |-> (rsp_occupancy == '0 && rsp_popped_value == '0))
      else $error("empty status with wrong occupancy or value");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && rsp_status == STATUS_OK)
         |-> (rsp_occupancy == $past(rsp_occupancy) + COUNT_WIDTH'(1)
              || rsp_occupancy == $past(rsp_occupancy) - COUNT_WIDTH'(1)))
      else $error("occupancy moved by other than one");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_popped_value (rsp_popped_value),
   .rsp_status       (rsp_status),
   .rsp_occupancy    (rsp_occupancy)
);
